>>> hw/rtl/alpe_pkg.sv
// shared types, codes and reset constants of the led pulse encoder
`default_nettype none

package alpe_pkg;

    // request codes on the input word
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_PUSH = 1'b1;

    // configuration register indexes
    localparam logic [1:0] CFG_PERIOD    = 2'd0;
    localparam logic [1:0] CFG_HIGH_ONE  = 2'd1;
    localparam logic [1:0] CFG_HIGH_ZERO = 2'd2;
    localparam logic [1:0] CFG_LATCH     = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // configuration reset values
    localparam logic [7:0]  PERIOD_RST    = 8'd20;
    localparam logic [7:0]  HIGH_ONE_RST  = 8'd15;
    localparam logic [7:0]  HIGH_ZERO_RST = 8'd7;
    localparam logic [15:0] LATCH_RST     = 16'd4800;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // classified input word
    typedef struct packed {
        logic       is_push;
        logic [7:0] pixel_byte;
        logic       last_byte;
    } cmd_t;

    // result word
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic accepted;
        logic frame_done;
        logic underrun;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/alpe_front.sv
// front stage: takes input words and classifies them into commands
`default_nettype none

module alpe_front (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic          s_req_type,
    input  wire logic [7:0]    s_pixel_byte,
    input  wire logic          s_last_byte,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output alpe_pkg::cmd_t     cmd
);

    logic           front_valid_reg;
    logic           front_valid_next;
    alpe_pkg::cmd_t cmd_reg;
    alpe_pkg::cmd_t cmd_next;

    assign s_ready = !front_valid_reg || cmd_ready;

    always_comb begin
        front_valid_next = front_valid_reg;
        cmd_next         = cmd_reg;
        if (s_ready) begin
            front_valid_next   = s_valid;
            cmd_next.is_push   = (s_req_type == alpe_pkg::REQ_PUSH);
            cmd_next.pixel_byte = s_pixel_byte;
            cmd_next.last_byte = s_last_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = front_valid_reg;
    assign cmd       = cmd_reg;

endmodule

`default_nettype wire

>>> hw/rtl/alpe_queue.sv
// short command queue between front and back
`default_nettype none

module alpe_queue #(
    parameter int DEPTH = alpe_pkg::QUEUE_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire alpe_pkg::cmd_t in_cmd,
    output logic                out_valid,
    input  wire logic           out_ready,
    output alpe_pkg::cmd_t      out_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    alpe_pkg::cmd_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/alpe_back.sv
// back stage: bit timing engine, holding register, config and result register
`default_nettype none

module alpe_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [alpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [alpe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                              cmd_valid,
    output logic                                   cmd_ready,
    input  wire alpe_pkg::cmd_t                    cmd,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output alpe_pkg::result_t                      res
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SEND  = 2'd1;
    localparam logic [1:0] PH_LATCH = 2'd2;

    // configuration
    logic [7:0]  period_ticks_reg;
    logic [7:0]  high_one_ticks_reg;
    logic [7:0]  high_zero_ticks_reg;
    logic [15:0] latch_ticks_reg;

    // encoder state
    logic [1:0]  phase_reg,           phase_next;
    logic [7:0]  tick_in_period_reg,  tick_in_period_next;
    logic [2:0]  bit_position_reg,    bit_position_next;
    logic [7:0]  shift_byte_reg,      shift_byte_next;
    logic        current_is_last_reg, current_is_last_next;
    logic [7:0]  holding_byte_reg,    holding_byte_next;
    logic        holding_valid_reg,   holding_valid_next;
    logic        holding_last_reg,    holding_last_next;
    logic [15:0] latch_count_reg,     latch_count_next;

    logic              res_valid_reg;
    alpe_pkg::result_t res_reg;
    alpe_pkg::result_t res_next;

    logic        pop;
    logic        cur_bit;
    logic [7:0]  high_ticks;
    logic [8:0]  tick_sum;
    logic [15:0] latch_inc;

    assign cmd_ready = !res_valid_reg || res_ready;
    assign pop       = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        phase_next           = phase_reg;
        tick_in_period_next  = tick_in_period_reg;
        bit_position_next    = bit_position_reg;
        shift_byte_next      = shift_byte_reg;
        current_is_last_next = current_is_last_reg;
        holding_byte_next    = holding_byte_reg;
        holding_valid_next   = holding_valid_reg;
        holding_last_next    = holding_last_reg;
        latch_count_next     = latch_count_reg;
        res_next             = '0;
        cur_bit              = 1'b0;
        high_ticks           = '0;
        tick_sum             = '0;
        latch_inc            = '0;

        if (cmd.is_push) begin
            res_next.busy_res = (phase_reg == PH_SEND) || (phase_reg == PH_LATCH);
            if (!holding_valid_reg) begin
                holding_byte_next  = cmd.pixel_byte;
                holding_last_next  = cmd.last_byte;
                holding_valid_next = 1'b1;
                res_next.accepted  = 1'b1;
            end
        end else begin
            // idle with a held byte: load it, this tick opens its first bit
            if (phase_reg != PH_SEND && phase_reg != PH_LATCH && holding_valid_reg) begin
                shift_byte_next      = holding_byte_reg;
                current_is_last_next = holding_last_reg;
                holding_valid_next   = 1'b0;
                bit_position_next    = '0;
                tick_in_period_next  = '0;
                phase_next           = PH_SEND;
            end

            if (phase_next == PH_SEND) begin
                cur_bit             = shift_byte_next[3'd7 - bit_position_next];
                high_ticks          = cur_bit ? high_one_ticks_reg : high_zero_ticks_reg;
                res_next.busy_res   = 1'b1;
                res_next.line_level = (tick_in_period_next < high_ticks);
                tick_sum            = {1'b0, tick_in_period_next} + 9'd1;
                if (tick_sum >= {1'b0, period_ticks_reg}) begin
                    tick_in_period_next = '0;
                    if (bit_position_next == 3'd7) begin
                        if (!current_is_last_next && holding_valid_next) begin
                            shift_byte_next      = holding_byte_reg;
                            current_is_last_next = holding_last_reg;
                            holding_valid_next   = 1'b0;
                            bit_position_next    = '0;
                        end else begin
                            res_next.underrun = !current_is_last_next;
                            latch_count_next  = '0;
                            if (latch_ticks_reg == '0) begin
                                res_next.frame_done = 1'b1;
                                phase_next          = PH_IDLE;
                            end else begin
                                phase_next = PH_LATCH;
                            end
                        end
                    end else begin
                        bit_position_next = bit_position_next + 3'd1;
                    end
                end else begin
                    tick_in_period_next = tick_in_period_next + 8'd1;
                end
            end else if (phase_next == PH_LATCH) begin
                res_next.busy_res = 1'b1;
                latch_inc         = latch_count_reg + 16'd1;
                latch_count_next  = latch_inc;
                if (latch_inc >= latch_ticks_reg) begin
                    res_next.frame_done = 1'b1;
                    phase_next          = PH_IDLE;
                    latch_count_next    = '0;
                end
            end else begin
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_ticks_reg    <= alpe_pkg::PERIOD_RST;
            high_one_ticks_reg  <= alpe_pkg::HIGH_ONE_RST;
            high_zero_ticks_reg <= alpe_pkg::HIGH_ZERO_RST;
            latch_ticks_reg     <= alpe_pkg::LATCH_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                alpe_pkg::CFG_PERIOD:    period_ticks_reg    <= cfg_wdata[7:0];
                alpe_pkg::CFG_HIGH_ONE:  high_one_ticks_reg  <= cfg_wdata[7:0];
                alpe_pkg::CFG_HIGH_ZERO: high_zero_ticks_reg <= cfg_wdata[7:0];
                alpe_pkg::CFG_LATCH:     latch_ticks_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_IDLE;
            tick_in_period_reg  <= '0;
            bit_position_reg    <= '0;
            shift_byte_reg      <= '0;
            current_is_last_reg <= 1'b0;
            holding_valid_reg   <= 1'b0;
            holding_last_reg    <= 1'b0;
            latch_count_reg     <= '0;
            res_valid_reg       <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg           <= phase_next;
                tick_in_period_reg  <= tick_in_period_next;
                bit_position_reg    <= bit_position_next;
                shift_byte_reg      <= shift_byte_next;
                current_is_last_reg <= current_is_last_next;
                holding_valid_reg   <= holding_valid_next;
                holding_last_reg    <= holding_last_next;
                latch_count_reg     <= latch_count_next;
            end
            if (cmd_ready) begin
                res_valid_reg <= cmd_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            holding_byte_reg <= holding_byte_next;
            res_reg          <= res_next;
        end
    end

    // a push result never drives the line
    a_push_line_low: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && cmd.is_push) |-> !res_next.line_level)
        else $error("push word drove the line high");

    // a refused push leaves the held byte in place
    a_refused_keeps_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && cmd.is_push && holding_valid_reg) |=> holding_valid_reg)
        else $error("refused push dropped the held byte");

    // a tick in idle with nothing held stays idle
    a_idle_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !cmd.is_push && !holding_valid_reg
         && phase_reg != PH_SEND && phase_reg != PH_LATCH) |=> (phase_reg == PH_IDLE))
        else $error("encoder left idle with no byte held");

    // a result only leaves the register when taken
    a_res_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !res_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("result register changed while stalled");

endmodule

`default_nettype wire

>>> hw/rtl/addressable_led_pulse_encoder_unit.sv
// top level of the addressable led pulse encoder
`default_nettype none

// channel   dir  handshake          payload
// s_        in   s_valid/s_ready    s_req_type, s_pixel_byte, s_last_byte
// m_        out  m_valid/m_ready    m_line_level, m_busy_res, m_accepted,
//                                   m_frame_done, m_underrun
// cfg_      in   cfg_we             cfg_index, cfg_wdata
//
// one word per clock sustained while m_ready is high; the back stage settles
// one word each cycle its result register is free; an accepted word passes
// the front register, then a queue entry, then the result register
// aresetn is synchronous, active low; config returns to its reset values
// a stalled m_ready fills the result register, then the queue, then the front
// register before s_ready drops

module addressable_led_pulse_encoder_unit #(
    parameter int QUEUE_DEPTH = alpe_pkg::QUEUE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration writes
    input  wire logic                              cfg_we,
    input  wire logic [alpe_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [alpe_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // input words
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_req_type,
    input  wire logic [7:0]                        s_pixel_byte,
    input  wire logic                              s_last_byte,
    // result words
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_line_level,
    output logic                                   m_busy_res,
    output logic                                   m_accepted,
    output logic                                   m_frame_done,
    output logic                                   m_underrun
);

    // front to queue
    logic              front_valid;
    logic              front_ready;
    alpe_pkg::cmd_t    front_cmd;

    // queue to back
    logic              back_valid;
    logic              back_ready;
    alpe_pkg::cmd_t    back_cmd;

    alpe_pkg::result_t result;

    // classify tick and push words
    alpe_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_pixel_byte (s_pixel_byte),
        .s_last_byte  (s_last_byte),
        .cmd_valid    (front_valid),
        .cmd_ready    (front_ready),
        .cmd          (front_cmd)
    );

    // decouples front stalls from back stalls
    alpe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    // bit timing, holding register and latch count
    alpe_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (result)
    );

    assign m_line_level = result.line_level;
    assign m_busy_res   = result.busy_res;
    assign m_accepted   = result.accepted;
    assign m_frame_done = result.frame_done;
    assign m_underrun   = result.underrun;

endmodule

`default_nettype wire
